// ----- design/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, codes and constant match strings for the HTTP response head
// parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	// Match string lengths
	localparam int MAGIC_N = 5;
	localparam int LEN_N   = 15;
	localparam int TYPE_N  = 13;
	localparam int CLASS_N = 4;
	localparam int CLASS_W = 12;

	// Reset value of the head size limit
	localparam logic [15:0] MAX_HDR_RESET = 16'd4096;

	// Result status codes
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NOT_HTTP = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// Media class codes; known classes follow CT_UNSET in table order
	localparam logic [2:0] CT_UNSET = 3'd0;
	localparam logic [2:0] CT_OTHER = 3'd5;

	localparam logic [7:0] MAGIC_TXT [MAGIC_N] = '{"H", "T", "T", "P", "/"};

	localparam logic [7:0] LEN_TXT [LEN_N] = '{
		"C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h", ":"
	};

	localparam logic [7:0] TYPE_TXT [TYPE_N] = '{
		"C", "o", "n", "t", "e", "n", "t", "-", "T", "y", "p", "e", ":"
	};

	// Known content classes, padded with NUL past their length
	localparam logic [7:0] CLASS_TXT [CLASS_N][CLASS_W] = '{
		'{"t", "e", "x", "t", "/", "p", "l", "a", "i", "n", 8'h00, 8'h00},
		'{"t", "e", "x", "t", "/", "x", "m", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "e", "x", "t", "/", "h", "t", "m", "l", 8'h00, 8'h00, 8'h00},
		'{"o", "c", "t", "e", "t", "-", "s", "t", "r", "e", "a", "m"}
	};

	localparam logic [4:0] CLASS_LEN [CLASS_N] = '{5'd10, 5'd8, 5'd9, 5'd12};

	// One received beat after the input register
	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_start;
	} beat_t;

	// One result item
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] body_length;
		logic [2:0]         media_class;
		logic [15:0]        header_bytes;
	} result_t;

	function automatic logic [7:0] magic_char(logic [4:0] i);
		if (i < 5'(MAGIC_N)) begin
			return MAGIC_TXT[i[2:0]];
		end
		return 8'h00;
	endfunction

	function automatic logic [7:0] len_char(logic [4:0] i);
		if (i < 5'(LEN_N)) begin
			return LEN_TXT[i[3:0]];
		end
		return 8'h00;
	endfunction

	function automatic logic [7:0] type_char(logic [4:0] i);
		if (i < 5'(TYPE_N)) begin
			return TYPE_TXT[i[3:0]];
		end
		return 8'h00;
	endfunction

	function automatic logic [7:0] class_char(logic [1:0] k, logic [4:0] i);
		if (i < 5'(CLASS_W)) begin
			return CLASS_TXT[k][i[3:0]];
		end
		return 8'h00;
	endfunction

endpackage

// ----- design/hrhp_in_if.sv -----
// ----------------------------------------------------------------------------
// hrhp_in_if
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface hrhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_start;

	modport source (output valid, output data_byte, output message_start, input ready);
	modport sink (input valid, input data_byte, input message_start, output ready);
endinterface

// ----- design/hrhp_out_if.sv -----
// ----------------------------------------------------------------------------
// hrhp_out_if
// Valid/ready channel carrying one parse result per beat.
// ----------------------------------------------------------------------------
interface hrhp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] body_length;
	logic [2:0]         media_class;
	logic [15:0]        header_bytes;

	modport source (
		output valid, output status, output body_length,
		output media_class, output header_bytes, input ready
	);
	modport sink (
		input valid, input status, input body_length,
		input media_class, input header_bytes, output ready
	);
endinterface

// ----- design/hrhp_in_reg.sv -----
// ----------------------------------------------------------------------------
// hrhp_in_reg
// Input register: captures one byte beat and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module hrhp_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	hrhp_in_if.sink        data,
	input  logic           advance,
	output logic           valid_s1,
	output hrhp_pkg::beat_t beat_s1
);

	// Accept a beat when the stage is empty or drains this cycle
	assign data.ready = !valid_s1 || advance;

	// Hold valid until the parser consumes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	// Capture payload on accept
	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			beat_s1.data_byte     <= data.data_byte;
			beat_s1.message_start <= data.message_start;
		end
	end

endmodule

// ----- design/hrhp_parser.sv -----
// ----------------------------------------------------------------------------
// hrhp_parser
// Per-byte parse state: prefix check, line splitting, header name match,
// Content-Length number scan, Content-Type classing, head size limit.
// ----------------------------------------------------------------------------
module hrhp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  hrhp_pkg::beat_t   beat_s1,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              slot_free,
	output logic              advance,
	output logic              res_valid,
	output hrhp_pkg::result_t res
);

	typedef enum logic [1:0] {PH_PREFIX, PH_LINES, PH_IDLE} phase_t;
	typedef enum logic [1:0] {K_UNKNOWN, K_LENGTH, K_TYPE, K_OTHER} kind_t;
	typedef enum logic [1:0] {N_PRE, N_SIGN, N_DIGITS, N_DONE} nstage_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  pos;
		logic [1:0]  pflags;
		logic [31:0] acc;
		logic        neg;
		nstage_t     nstage;
		logic        seen;
		logic [3:0]  tflags;
		logic [4:0]  tcount;
		logic        tstop;
	} line_st_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [4:0]  POS_MAX   = 5'd31;
	localparam logic [35:0] MAG_CAP   = 36'h080000000;
	localparam logic [31:0] POS_LIMIT = 32'h7FFFFFFF;

	localparam line_st_t MSG_CLEAR = '{
		kind: K_UNKNOWN, pos: 5'd0, pflags: 2'b11, acc: 32'd0, neg: 1'b0,
		nstage: N_PRE, seen: 1'b0, tflags: 4'hF, tcount: 5'd0, tstop: 1'b0
	};

	phase_t      phase_q;
	line_st_t    line_q;
	logic        prev_cr_q;
	logic [31:0] len_res_q;
	logic [2:0]  type_res_q;
	logic [15:0] count_q;
	logic [15:0] max_hdr_q;

	phase_t      phase_d;
	line_st_t    line_d;
	logic        prev_cr_d;
	logic [31:0] len_res_d;
	logic [2:0]  type_res_d;
	logic [15:0] count_d;
	logic        do_line;

	// Fold one ordinary line byte into the line state
	function automatic line_st_t line_byte(line_st_t s, logic [7:0] c);
		line_st_t    n;
		logic [4:0]  pos;
		logic [1:0]  fl;
		logic        digit;
		logic        space;
		logic [35:0] prod;
		logic [31:0] acc_next;
		n     = s;
		pos   = s.pos;
		fl    = s.pflags;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
			(c == CH_VT) || (c == CH_FF) || (c == CH_CR);
		// acc * 10 + digit, saturated to the magnitude of the most negative value
		prod = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {32'd0, c[3:0]};
		acc_next = (prod > MAG_CAP) ? MAG_CAP[31:0] : prod[31:0];

		if (s.kind == K_UNKNOWN) begin
			// Narrow the header name candidates
			if (fl[0] && (pos >= 5'(hrhp_pkg::LEN_N) || c != hrhp_pkg::len_char(pos))) begin
				fl[0] = 1'b0;
			end
			if (fl[1] && (pos >= 5'(hrhp_pkg::TYPE_N) || c != hrhp_pkg::type_char(pos))) begin
				fl[1] = 1'b0;
			end
			pos = pos + 5'd1;
			if (fl[0] && pos == 5'(hrhp_pkg::LEN_N)) begin
				n.kind   = K_LENGTH;
				n.acc    = 32'd0;
				n.neg    = 1'b0;
				n.nstage = N_PRE;
				n.seen   = 1'b0;
			end else if (fl[1] && pos == 5'(hrhp_pkg::TYPE_N)) begin
				n.kind   = K_TYPE;
				n.tflags = 4'hF;
				n.tcount = 5'd0;
				n.tstop  = 1'b0;
			end else if (fl == 2'b00) begin
				n.kind = K_OTHER;
			end
			n.pos    = pos;
			n.pflags = fl;
		end else if (s.kind == K_LENGTH) begin
			// Scan blanks, sign, then digits up to the first non-digit
			unique case (s.nstage)
				N_PRE: begin
					if (space) begin
						n.nstage = N_PRE;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						n.neg    = (c == CH_MINUS);
						n.nstage = N_SIGN;
					end else if (digit) begin
						n.acc    = acc_next;
						n.seen   = 1'b1;
						n.nstage = N_DIGITS;
					end else begin
						n.nstage = N_DONE;
					end
				end
				N_SIGN, N_DIGITS: begin
					if (digit) begin
						n.acc    = acc_next;
						n.seen   = 1'b1;
						n.nstage = N_DIGITS;
					end else begin
						n.nstage = N_DONE;
					end
				end
				N_DONE: begin
					n.nstage = N_DONE;
				end
				default: begin
					n.nstage = N_DONE;
				end
			endcase
		end else if (s.kind == K_TYPE && !s.tstop) begin
			// Match the value against the known classes, skipping spaces
			if (c == CH_CR || c == CH_LF) begin
				n.tstop = 1'b1;
			end else if (c != CH_SPACE) begin
				for (int k = 0; k < hrhp_pkg::CLASS_N; k++) begin
					if (s.tflags[k] && (s.tcount >= hrhp_pkg::CLASS_LEN[2'(k)] ||
						c != hrhp_pkg::class_char(2'(k), s.tcount))) begin
						n.tflags[k] = 1'b0;
					end
				end
				if (s.tcount < POS_MAX) begin
					n.tcount = s.tcount + 5'd1;
				end
			end
		end
		return n;
	endfunction

	// Next state and result for the beat in the input register
	always_comb begin
		phase_d    = phase_q;
		line_d     = line_q;
		prev_cr_d  = prev_cr_q;
		len_res_d  = len_res_q;
		type_res_d = type_res_q;
		count_d    = count_q;
		res_valid  = 1'b0;
		res.status = hrhp_pkg::ST_DONE;
		do_line    = 1'b0;

		if (beat_s1.message_start) begin
			phase_d    = PH_PREFIX;
			line_d     = MSG_CLEAR;
			prev_cr_d  = 1'b0;
			len_res_d  = 32'hFFFFFFFF;
			type_res_d = hrhp_pkg::CT_UNSET;
			count_d    = 16'd0;
		end

		if (phase_d == PH_PREFIX || phase_d == PH_LINES) begin
			if (count_d >= max_hdr_q) begin
				res_valid  = 1'b1;
				res.status = hrhp_pkg::ST_TOO_LONG;
				phase_d    = PH_IDLE;
			end else begin
				count_d = count_d + 16'd1;
				if (phase_d == PH_PREFIX) begin
					// Check the HTTP/ prefix
					if (line_d.pos >= 5'(hrhp_pkg::MAGIC_N) ||
						beat_s1.data_byte != hrhp_pkg::magic_char(line_d.pos)) begin
						res_valid  = 1'b1;
						res.status = hrhp_pkg::ST_NOT_HTTP;
						phase_d    = PH_IDLE;
					end else begin
						line_d.pos = line_d.pos + 5'd1;
						if (line_d.pos == 5'(hrhp_pkg::MAGIC_N)) begin
							phase_d     = PH_LINES;
							line_d.kind = K_OTHER;
						end
					end
				end else begin
					do_line = 1'b1;
					if (prev_cr_d) begin
						prev_cr_d = 1'b0;
						if (beat_s1.data_byte == CH_LF) begin
							do_line = 1'b0;
							if (line_d.pos == 5'd0) begin
								// Blank line ends the head
								res_valid  = 1'b1;
								res.status = hrhp_pkg::ST_DONE;
								phase_d    = PH_IDLE;
							end else begin
								// Close the line and commit its header value
								if (line_d.kind == K_LENGTH && line_d.seen) begin
									if (line_d.neg) begin
										len_res_d = 32'd0 - line_d.acc;
									end else begin
										len_res_d = (line_d.acc > POS_LIMIT) ?
											POS_LIMIT : line_d.acc;
									end
								end else if (line_d.kind == K_TYPE) begin
									type_res_d = hrhp_pkg::CT_OTHER;
									for (int k = hrhp_pkg::CLASS_N - 1; k >= 0; k--) begin
										if (line_d.tflags[k] &&
											line_d.tcount == hrhp_pkg::CLASS_LEN[2'(k)]) begin
											type_res_d = 3'(k) + 3'd1;
										end
									end
								end
								line_d.pos    = 5'd0;
								line_d.kind   = K_UNKNOWN;
								line_d.pflags = 2'b11;
							end
						end else begin
							// Lone CR is an ordinary line byte
							line_d = line_byte(line_d, CH_CR);
						end
					end
					if (do_line) begin
						if (beat_s1.data_byte == CH_CR) begin
							prev_cr_d = 1'b1;
						end else begin
							line_d = line_byte(line_d, beat_s1.data_byte);
						end
					end
				end
			end
		end

		res.body_length  = len_res_d;
		res.media_class  = type_res_d;
		res.header_bytes = count_d;
	end

	// Take the beat unless it makes a result and the output slot is busy
	assign advance = valid_s1 && (!res_valid || slot_free);

	// Hold parse state; advance on each consumed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PREFIX;
			line_q     <= MSG_CLEAR;
			prev_cr_q  <= 1'b0;
			len_res_q  <= 32'hFFFFFFFF;
			type_res_q <= hrhp_pkg::CT_UNSET;
			count_q    <= 16'd0;
		end else if (advance) begin
			phase_q    <= phase_d;
			line_q     <= line_d;
			prev_cr_q  <= prev_cr_d;
			len_res_q  <= len_res_d;
			type_res_q <= type_res_d;
			count_q    <= count_d;
		end
	end

	// Head size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q <= hrhp_pkg::MAX_HDR_RESET;
		end else if (cfg_we) begin
			max_hdr_q <= cfg_wdata;
		end
	end

	// A delivered result parks the parser until the next message
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after a result");

	// Name matching settles by the end of the longest header name
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_q.pos <= 5'd16)
		else $error("line position past header name range");

	// During the prefix check only the prefix index moves
	a_prefix_state: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PREFIX) |-> (line_q.pos < 5'd5 && line_q.kind == K_UNKNOWN))
		else $error("bad line state during prefix check");

	// A digit seen means the scan is in or past the digit run
	a_seen_stage: assert property (@(posedge clk) disable iff (!arst_n)
		line_q.seen |-> (line_q.nstage == N_DIGITS || line_q.nstage == N_DONE))
		else $error("digit flag set outside digit run");

endmodule

// ----- design/hrhp_out_reg.sv -----
// ----------------------------------------------------------------------------
// hrhp_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module hrhp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hrhp_pkg::result_t res,
	output logic              slot_free,
	hrhp_out_if.source        result
);

	logic              valid_q;
	hrhp_pkg::result_t res_q;

	// Slot is free when empty or drained this cycle
	assign slot_free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result.valid        = valid_q;
	assign result.status       = res_q.status;
	assign result.body_length  = res_q.body_length;
	assign result.media_class  = res_q.media_class;
	assign result.header_bytes = res_q.header_bytes;

endmodule

// ----- design/http_response_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// http_response_header_parser_core
// Byte-serial HTTP response head parser with one result per message.
// ----------------------------------------------------------------------------
// Takes one response byte per clock except while stalled as described below:
// each accepted byte is registered, then updates the parser state. A result
// (head complete, not an HTTP message, or head too long) is loaded into the
// output register when the parser consumes the byte that caused it, and is
// held until taken; input is stalled only when a new result is due while
// the previous one still waits there. Bytes after a result are dropped until
// a beat with message_start set. max_header_bytes is written through
// cfg_we/cfg_wdata and resets to 4096.
module http_response_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	hrhp_in_if.sink     data,
	hrhp_out_if.source  result,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic              valid_s1;
	hrhp_pkg::beat_t   beat_s1;
	logic              advance;
	logic              res_valid;
	hrhp_pkg::result_t res;
	logic              slot_free;

	// Register the incoming byte beat
	hrhp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.data     (data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	// Update parse state and form the result
	hrhp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.beat_s1   (beat_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.slot_free (slot_free),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	// Hold the result for the sink
	hrhp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.slot_free (slot_free),
		.result    (result)
	);

endmodule
